/* sv/rmq_pkg.sv */
package rmq_pkg;
   localparam int FRAC_BITS = 14;
   localparam int EPS = (1 << FRAC_BITS) / 10000000;
   // root argument width: sums of four 16-bit terms
   localparam int ARG_W = 19;
   localparam int RAD_W = ARG_W + FRAC_BITS;
   localparam int ROOT_W = (RAD_W + 1) / 2;
   localparam int NUM_W = 18;
   localparam int QN_W = NUM_W + FRAC_BITS;
   localparam int DEN_W = ROOT_W + 1;
   localparam int SQ_STEPS = ROOT_W;
   localparam int DV_STEPS = QN_W;

   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_X     = 2'd1,
      CASE_Y     = 2'd2,
      CASE_Z     = 2'd3
   } case_type;

   // item state carried along the root and divide pipelines
   typedef struct packed {
      case_type                  sel;
      logic                      bad;
      logic signed [NUM_W-1:0]   n0;
      logic signed [NUM_W-1:0]   n1;
      logic signed [NUM_W-1:0]   n2;
   } meta_type;

   function automatic logic signed [15:0] sat16(input logic signed [QN_W:0] v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return v[15:0];
   endfunction
endpackage

/* sv/rmq_front.sv */
// Select the case, form the root argument and the three numerators.
module rmq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [143:0]                  in_data,
   output logic                          out_valid,
   output rmq_pkg::meta_type             out_meta,
   output logic [rmq_pkg::ARG_W-1:0]     out_arg
);
   import rmq_pkg::*;
   logic signed [15:0] m [9];
   logic signed [ARG_W:0] one_s, tr, a;
   logic signed [NUM_W-1:0] e0, e1, e2;
   case_type sel;
   meta_type meta_in;
   logic valid_ff;
   meta_type meta_ff;
   logic [ARG_W-1:0] arg_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) m[i] = in_data[16*i +: 16];
      one_s = (ARG_W+1)'(1 << FRAC_BITS);
      tr = (ARG_W+1)'(m[0]) + (ARG_W+1)'(m[4]) + (ARG_W+1)'(m[8]) + one_s;
      e0 = '0; e1 = '0; e2 = '0;
      if (tr > (ARG_W+1)'(EPS)) begin
         sel = CASE_TRACE; a = tr;
         e0 = NUM_W'(m[5]) - NUM_W'(m[7]);
         e1 = NUM_W'(m[6]) - NUM_W'(m[2]);
         e2 = NUM_W'(m[1]) - NUM_W'(m[3]);
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         sel = CASE_X;
         a = (ARG_W+1)'(m[0]) + one_s - (ARG_W+1)'(m[4]) - (ARG_W+1)'(m[8]);
         e0 = NUM_W'(m[7]) - NUM_W'(m[5]);
         e1 = NUM_W'(m[3]) + NUM_W'(m[1]);
         e2 = NUM_W'(m[6]) + NUM_W'(m[2]);
      end else if (m[4] > m[8]) begin
         sel = CASE_Y;
         a = (ARG_W+1)'(m[4]) + one_s - (ARG_W+1)'(m[0]) - (ARG_W+1)'(m[8]);
         e0 = NUM_W'(m[6]) - NUM_W'(m[2]);
         e1 = NUM_W'(m[3]) + NUM_W'(m[1]);
         e2 = NUM_W'(m[7]) + NUM_W'(m[5]);
      end else begin
         sel = CASE_Z;
         a = (ARG_W+1)'(m[8]) + one_s - (ARG_W+1)'(m[0]) - (ARG_W+1)'(m[4]);
         e0 = NUM_W'(m[3]) - NUM_W'(m[1]);
         e1 = NUM_W'(m[6]) + NUM_W'(m[2]);
         e2 = NUM_W'(m[7]) + NUM_W'(m[5]);
      end
      meta_in.sel = sel;
      meta_in.bad = (a <= 0);
      meta_in.n0 = e0; meta_in.n1 = e1; meta_in.n2 = e2;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
      if (adv) begin
         meta_ff <= meta_in;
         arg_ff <= meta_in.bad ? '0 : a[ARG_W-1:0];
      end
   end
   assign out_valid = valid_ff;
   assign out_meta = meta_ff;
   assign out_arg = arg_ff;
endmodule

/* sv/rmq_sqrt.sv */
// Pipelined restoring square root, one result bit per stage.
module rmq_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  rmq_pkg::meta_type             in_meta,
   input  logic [rmq_pkg::ARG_W-1:0]     in_arg,
   output logic                          out_valid,
   output rmq_pkg::meta_type             out_meta,
   output logic [rmq_pkg::ROOT_W-1:0]    out_root
);
   import rmq_pkg::*;
   localparam int RW = 2*ROOT_W;
   logic              vld_ff [SQ_STEPS+1];
   meta_type          meta_ff [SQ_STEPS+1];
   logic [RW-1:0]     rad_ff [SQ_STEPS+1];
   logic [ROOT_W+1:0] rem_ff [SQ_STEPS+1];
   logic [ROOT_W-1:0] root_ff [SQ_STEPS+1];

   always_comb begin
      vld_ff[0] = in_valid;
      meta_ff[0] = in_meta;
      rad_ff[0] = RW'({in_arg, {FRAC_BITS{1'b0}}});
      rem_ff[0] = '0;
      root_ff[0] = '0;
   end

   for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
      logic [ROOT_W+1:0] rem_in, trial;
      logic [ROOT_W-1:0] root_in;
      always_comb begin
         rem_in = {rem_ff[s][ROOT_W-1:0], rad_ff[s][RW-1 -: 2]};
         trial = {root_ff[s], 2'b01};
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            root_in = {root_ff[s][ROOT_W-2:0], 1'b1};
         end else begin
            root_in = {root_ff[s][ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[s+1] <= 1'b0;
         else if (adv) vld_ff[s+1] <= vld_ff[s];
         if (adv) begin
            meta_ff[s+1] <= meta_ff[s];
            rad_ff[s+1] <= rad_ff[s] << 2;
            rem_ff[s+1] <= rem_in;
            root_ff[s+1] <= root_in;
         end
      end
   end

   always_comb begin
      out_valid = vld_ff[SQ_STEPS];
      out_meta = meta_ff[SQ_STEPS];
      out_meta.bad = meta_ff[SQ_STEPS].bad || (root_ff[SQ_STEPS] == '0);
      out_root = root_ff[SQ_STEPS];
   end
endmodule

/* sv/rmq_div.sv */
// Three pipelined restoring dividers, one quotient bit per stage, then saturate.
module rmq_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  rmq_pkg::meta_type             in_meta,
   input  logic [rmq_pkg::ROOT_W-1:0]    in_root,
   output logic                          out_valid,
   output logic [66:0]                   out_data
);
   import rmq_pkg::*;
   localparam int RMW = DEN_W + 1;
   logic              vld_ff [DV_STEPS+1];
   meta_type          meta_ff [DV_STEPS+1];
   logic [ROOT_W-1:0] root_ff [DV_STEPS+1];
   logic [QN_W-1:0]   mag_ff [DV_STEPS+1][3];
   logic [RMW-1:0]    rem_ff [DV_STEPS+1][3];
   logic [QN_W-1:0]   quo_ff [DV_STEPS+1][3];
   logic signed [NUM_W-1:0] num [3];

   always_comb begin
      num[0] = in_meta.n0; num[1] = in_meta.n1; num[2] = in_meta.n2;
      vld_ff[0] = in_valid;
      meta_ff[0] = in_meta;
      root_ff[0] = in_root;
      for (int k = 0; k < 3; k++) begin
         mag_ff[0][k] = {(num[k] < 0) ? NUM_W'(-num[k]) : NUM_W'(num[k]),
                         {FRAC_BITS{1'b0}}};
         rem_ff[0][k] = '0;
         quo_ff[0][k] = '0;
      end
   end

   for (genvar s = 0; s < DV_STEPS; s++) begin : g_step
      logic [RMW-1:0] rem_in [3];
      logic [QN_W-1:0] quo_in [3];
      logic [RMW-1:0] den;
      always_comb begin
         den = RMW'({root_ff[s], 1'b0});
         for (int k = 0; k < 3; k++) begin
            rem_in[k] = {rem_ff[s][k][RMW-2:0], mag_ff[s][k][QN_W-1]};
            quo_in[k] = {quo_ff[s][k][QN_W-2:0], 1'b0};
            if (rem_in[k] >= den) begin
               rem_in[k] = rem_in[k] - den;
               quo_in[k][0] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[s+1] <= 1'b0;
         else if (adv) vld_ff[s+1] <= vld_ff[s];
         if (adv) begin
            meta_ff[s+1] <= meta_ff[s];
            root_ff[s+1] <= root_ff[s];
            for (int k = 0; k < 3; k++) begin
               mag_ff[s+1][k] <= mag_ff[s][k] << 1;
               rem_ff[s+1][k] <= rem_in[k];
               quo_ff[s+1][k] <= quo_in[k];
            end
         end
      end
   end

   // Apply signs, saturate, and place components by case
   logic signed [15:0] q [3];
   logic signed [15:0] half, qx, qy, qz, qw;
   meta_type mt;
   logic sg;
   always_comb begin
      mt = meta_ff[DV_STEPS];
      sg = 1'b0;
      for (int k = 0; k < 3; k++) begin
         case (k)
            0: sg = mt.n0[NUM_W-1];
            1: sg = mt.n1[NUM_W-1];
            default: sg = mt.n2[NUM_W-1];
         endcase
         q[k] = sg ? sat16(-$signed({1'b0, quo_ff[DV_STEPS][k]}))
                   : sat16($signed({1'b0, quo_ff[DV_STEPS][k]}));
      end
      half = sat16((QN_W+1)'(root_ff[DV_STEPS] >> 1));
      case (mt.sel)
         CASE_TRACE: begin qw = half; qx = q[0]; qy = q[1]; qz = q[2]; end
         CASE_X:     begin qx = half; qw = q[0]; qy = q[1]; qz = q[2]; end
         CASE_Y:     begin qy = half; qw = q[0]; qx = q[1]; qz = q[2]; end
         default:    begin qz = half; qw = q[0]; qx = q[1]; qy = q[2]; end
      endcase
      if (mt.bad) begin
         qx = '0; qy = '0; qz = '0; qw = '0;
      end
      out_data = {mt.bad, mt.sel, qw, qz, qy, qx};
   end
   assign out_valid = vld_ff[DV_STEPS];
endmodule

/* sv/rotation_matrix_to_quaternion_top.sv */
// Rotation matrix to quaternion, four-case trace method, Q2.14 fixed point.
// Accepts one matrix every clock cycle while the output side does not stall;
// each result passes the front register, 17 square-root stages, 32 divider
// stages and the output register. A stall on rsp_tready freezes the whole
// pipeline; req_tready stays high while the output register is empty or being
// drained.
module rotation_matrix_to_quaternion_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [143:0]  req_tdata,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata   // qx,qy,qz,qw,case_taken,invalid,pad 5
);
   import rmq_pkg::*;
   logic adv;
   logic f_valid, s_valid, d_valid;
   meta_type f_meta, s_meta;
   logic [ARG_W-1:0] f_arg;
   logic [ROOT_W-1:0] s_root;
   logic [66:0] d_data;
   logic out_valid_ff;
   logic [66:0] out_data_ff;

   // advance the pipeline while the output register can take a transfer
   assign adv = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   rmq_front u_front (.clock, .reset, .adv, .in_valid(req_tvalid),
      .in_data(req_tdata), .out_valid(f_valid), .out_meta(f_meta), .out_arg(f_arg));
   rmq_sqrt u_sqrt (.clock, .reset, .adv, .in_valid(f_valid), .in_meta(f_meta),
      .in_arg(f_arg), .out_valid(s_valid), .out_meta(s_meta), .out_root(s_root));
   rmq_div u_div (.clock, .reset, .adv, .in_valid(s_valid), .in_meta(s_meta),
      .in_root(s_root), .out_valid(d_valid), .out_data(d_data));

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= d_valid;
      if (adv) out_data_ff <= d_data;
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'd0, out_data_ff};
endmodule

/* sv/rmq_checker.sv */
module rmq_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata
);
   // stalled output holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp held data changed");
   // input ready follows the output side
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");
   // invalid result carries zero components
   a_inv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66] |-> rsp_tdata[63:0] == 64'd0)
      else $error("invalid result not zero");
   // pad bits stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:67] == 5'd0)
      else $error("pad bits set");
endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);

/* test/rotation_matrix_to_quaternion_top_tb.sv */
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_top_tb;
   import rmq_pkg::*;

   localparam int LIMIT_CYCLES = 900000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic signed [15:0] ONE_Q = 16'sd16384;

   typedef struct packed {
      logic signed [15:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
   } matrix_t;

   typedef struct {
      logic signed [15:0] qx, qy, qz, qw;
      case_type           sel;
      logic               bad;
   } quat_t;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;  // m00,m01,m02,m10,m11,m12,m20,m21,m22
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [71:0]  rsp_tdata;      // qx,qy,qz,qw,case_taken,invalid,pad 5

   quat_t expected_quats[$];
   int    error_count = 0;
   int    cycle_count = 0;
   bit    hold_off = 0;   // long receiver stall
   bit    no_gaps = 0;

   rotation_matrix_to_quaternion_top dut (.*);

   initial forever #6 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint root_of(longint v);
      longint res, bit_v;
      res = 0;
      bit_v = 64'sd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v -= res + bit_v;
            res = (res >>> 1) + bit_v;
         end else begin
            res >>>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] scaled_quot(longint n, longint r);
      longint q;
      if (r == 0) return 0;
      q = (n * 16384) / (2 * r);  // SV division truncates toward zero
      return clip16(q);
   endfunction

   // Predict quaternion from one matrix
   function automatic quat_t predict_quat(matrix_t m);
      quat_t q;
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, arg, r;
      logic signed [15:0] half;
      a00 = m.m00; a01 = m.m01; a02 = m.m02;
      a10 = m.m10; a11 = m.m11; a12 = m.m12;
      a20 = m.m20; a21 = m.m21; a22 = m.m22;
      q.qx = 0; q.qy = 0; q.qz = 0; q.qw = 0; q.bad = 0;
      tr = a00 + a11 + a22 + 16384;
      if (tr > EPS) begin
         q.sel = CASE_TRACE; arg = tr;
      end else if (a00 > a11 && a00 > a22) begin
         q.sel = CASE_X; arg = a00 + 16384 - a11 - a22;
      end else if (a11 > a22) begin
         q.sel = CASE_Y; arg = a11 + 16384 - a00 - a22;
      end else begin
         q.sel = CASE_Z; arg = a22 + 16384 - a00 - a11;
      end
      r = 0;
      if (arg <= 0) q.bad = 1;
      else begin
         r = root_of(arg << 14);
         if (r == 0) q.bad = 1;
      end
      if (!q.bad) begin
         half = clip16(r >>> 1);
         case (q.sel)
            CASE_TRACE: begin
               q.qw = half;
               q.qx = scaled_quot(a12 - a21, r);
               q.qy = scaled_quot(a20 - a02, r);
               q.qz = scaled_quot(a01 - a10, r);
            end
            CASE_X: begin
               q.qx = half;
               q.qw = scaled_quot(a21 - a12, r);
               q.qy = scaled_quot(a10 + a01, r);
               q.qz = scaled_quot(a20 + a02, r);
            end
            CASE_Y: begin
               q.qy = half;
               q.qw = scaled_quot(a20 - a02, r);
               q.qx = scaled_quot(a10 + a01, r);
               q.qz = scaled_quot(a21 + a12, r);
            end
            default: begin
               q.qz = half;
               q.qw = scaled_quot(a10 - a01, r);
               q.qx = scaled_quot(a20 + a02, r);
               q.qy = scaled_quot(a21 + a12, r);
            end
         endcase
      end
      return q;
   endfunction

   function automatic int draw_gap();
      if (no_gaps) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   // Send one matrix and queue its prediction at the transfer
   task automatic send_matrix(matrix_t m);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= m;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_quats.push_back(predict_quat(m));
      @(negedge clock);
   endtask

   // Receiver ready, drawn per cycle window
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            @(negedge clock);
         end else begin
            gap = draw_gap();
            if (gap > 0) begin
               rsp_tready <= 0;
               repeat (gap) @(negedge clock);
            end
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   // Check each result transfer
   always @(posedge clock) begin
      quat_t exp_q;
      logic signed [15:0] gx, gy, gz, gw;
      logic [1:0] gsel;
      logic gbad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         gx = rsp_tdata[15:0]; gy = rsp_tdata[31:16];
         gz = rsp_tdata[47:32]; gw = rsp_tdata[63:48];
         gsel = rsp_tdata[65:64]; gbad = rsp_tdata[66];
         if (expected_quats.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_tdata);
            error_count++;
         end else begin
            exp_q = expected_quats.pop_front();
            if (gx !== exp_q.qx || gy !== exp_q.qy || gz !== exp_q.qz ||
                gw !== exp_q.qw || gsel !== exp_q.sel || gbad !== exp_q.bad) begin
               $display("%0t mismatch expected %0d %0d %0d %0d case %0d bad %0b",
                        $time, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw,
                        exp_q.sel, exp_q.bad);
               $display("%0t            actual %0d %0d %0d %0d case %0d bad %0b",
                        $time, gx, gy, gz, gw, gsel, gbad);
               error_count++;
            end
         end
      end
   end

   function automatic matrix_t diag(logic signed [15:0] a, logic signed [15:0] b,
                                    logic signed [15:0] c);
      matrix_t m;
      m = '0;
      m.m00 = a; m.m11 = b; m.m22 = c;
      m.m01 = 16'($urandom); m.m02 = 16'($urandom); m.m10 = 16'($urandom);
      m.m12 = 16'($urandom); m.m20 = 16'($urandom); m.m21 = 16'($urandom);
      return m;
   endfunction

   function automatic matrix_t random_matrix();
      matrix_t m;
      int kind;
      m = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
      kind = $urandom_range(0, 9);
      // Negative trace steers toward the dominant cases
      if (kind < 4) begin
         m.m00 = 16'($urandom_range(0, 40000) - 32768);
         m.m11 = 16'($urandom_range(0, 40000) - 32768);
         m.m22 = 16'($urandom_range(0, 40000) - 32768);
      end else if (kind < 7) begin
         m.m00 = 16'($urandom_range(0, 32768) - 16384);
         m.m11 = 16'($urandom_range(0, 32768) - 16384);
         m.m22 = 16'($urandom_range(0, 32768) - 16384);
         m.m01 = 16'($urandom_range(0, 32768) - 16384);
         m.m10 = 16'($urandom_range(0, 32768) - 16384);
      end
      return m;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 0;
      while (expected_quats.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_matrix(diag(ONE_Q, ONE_Q, ONE_Q));
      send_matrix('0);
      send_matrix({9{16'sh7fff}});
      send_matrix({9{16'sh8000}});
      send_matrix(diag(-16'sd16384, -16'sd16384, -16'sd16384));  // trace at -2, z case
      send_matrix(diag(-16'sd8192, -16'sd4096, -16'sd4096));     // trace exactly 0
      send_matrix(diag(ONE_Q, -ONE_Q, -ONE_Q));
      send_matrix(diag(-ONE_Q, ONE_Q, -ONE_Q));
      send_matrix(diag(-ONE_Q, -ONE_Q, ONE_Q));
      send_matrix(diag(-ONE_Q, -ONE_Q, -ONE_Q));
      send_matrix(diag(16'sh8000, 16'sh8000, 16'sh8000));         // ties, z case
      send_matrix(diag(-16'sd6000, -16'sd6000, -16'sd6000));      // equal diagonal
      send_matrix(diag(16'sh7fff, 16'sh8000, 16'sh8000));         // x dominant, large root
      send_matrix(diag(16'sh8000, 16'sh7fff, 16'sh8000));
      send_matrix(diag(-16'sd1, 16'sh8000, 16'sh8000));
      send_matrix(diag(-16'sd16383, -16'sd16384, -16'sd16384));   // x case, wins by one
      send_matrix(diag(16'sh8000, 16'sh8000, -16'sd2));
      send_matrix(diag(16'sd1, 16'sd0, -16'sd16385));
      send_matrix(diag(-16'sd5462, -16'sd5461, -16'sd5461));
      wait_drained();
   endtask

   task automatic test_random(int count);
      repeat (count) send_matrix(random_matrix());
   endtask

   // Stall the output long enough to back up the pipeline
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (150) @(negedge clock);
            hold_off = 0;
         end
         begin
            no_gaps = 1;
            repeat (90) send_matrix(random_matrix());
            no_gaps = 0;
         end
      join
      wait_drained();
   endtask

   task automatic test_full_rate();
      no_gaps = 1;
      repeat (120) send_matrix(random_matrix());
      no_gaps = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random(700);
      wait_drained();
      test_backpressure();
      test_full_rate();
      test_random(700);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
